### hdl/fat_pkg.sv
package fat_pkg;

    localparam int MAX_ENTRIES = 10;
    localparam int STORE_BYTES = 1024;

    localparam int KEY_W   = 64;
    localparam int SIZE_W  = 10;
    localparam int ADDR_W  = 11;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 4;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    localparam logic [SIZE_W-1:0] FIRST_DATA_RESET = SIZE_W'(161);

    localparam logic [CMD_W-1:0] CMD_STORE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXISTS  = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd3;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic [KEY_W-1:0]  name;
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } entry_t;

    typedef struct packed {
        logic   we;
        idx_t   waddr;
        entry_t wdata;
        idx_t   raddr;
    } ram_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_SHIFT,
        S_TAIL,
        S_FINISH
    } state_t;

    // Bytes left above a given end address, saturating at zero.
    function automatic logic [ADDR_W-1:0] room_left(input logic [ADDR_W-1:0] end_addr);
        logic [ADDR_W-1:0] top;
        top = ADDR_W'(STORE_BYTES);
        room_left = (end_addr >= top) ? '0 : ADDR_W'(top - end_addr);
    endfunction

endpackage

### hdl/fat_if.sv
interface fat_req_if;
    logic                         valid;
    logic                         ready;
    logic [fat_pkg::CMD_W-1:0]    command;
    logic [fat_pkg::KEY_W-1:0]    name_key;
    logic [fat_pkg::SIZE_W-1:0]   file_size;

    modport source (output valid, command, name_key, file_size, input ready);
    modport sink   (input valid, command, name_key, file_size, output ready);
endinterface

interface fat_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fat_pkg::STAT_W-1:0]   status;
    logic [fat_pkg::INDEX_W-1:0]  entry_index;
    logic [fat_pkg::ADDR_W-1:0]   start_address;
    logic [fat_pkg::SIZE_W-1:0]   entry_size;
    logic [fat_pkg::COUNT_W-1:0]  file_count;
    logic [fat_pkg::ADDR_W-1:0]   free_bytes;

    modport source (output valid, status, entry_index, start_address, entry_size,
                    file_count, free_bytes, input ready);
    modport sink   (input valid, status, entry_index, start_address, entry_size,
                    file_count, free_bytes, output ready);
endinterface

interface fat_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [fat_pkg::SIZE_W-1:0]   data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### hdl/fat_ram.sv
module fat_ram
(
    input  logic              clk,
    input  fat_pkg::ram_req_t req,
    output fat_pkg::entry_t   rdata
);

    fat_pkg::entry_t mem [fat_pkg::MAX_ENTRIES];
    fat_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata_reg <= mem[req.raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/fat_ctrl.sv
module fat_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    fat_req_if.sink            req,
    fat_rsp_if.source          rsp,
    fat_cfg_if.sink            cfg,
    output fat_pkg::ram_req_t  ram_req,
    input  fat_pkg::entry_t    ram_rdata
);

    localparam int IDX_W  = fat_pkg::IDX_W;
    localparam int CNT_W  = fat_pkg::CNT_W;
    localparam int ADDR_W = fat_pkg::ADDR_W;
    localparam int SIZE_W = fat_pkg::SIZE_W;

    fat_pkg::state_t state_reg, state_next;

    logic [fat_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [fat_pkg::KEY_W-1:0]  key_reg, key_next;
    logic [SIZE_W-1:0]          size_reg, size_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [ADDR_W-1:0]          end_reg, end_next;
    logic [CNT_W-1:0]           ptr_reg, ptr_next;
    logic                       rvld_reg, rvld_next;
    logic [IDX_W-1:0]           rptr_reg, rptr_next;
    logic [IDX_W-1:0]           hit_idx_reg, hit_idx_next;
    logic [ADDR_W-1:0]          hit_addr_reg, hit_addr_next;
    logic [SIZE_W-1:0]          hit_size_reg, hit_size_next;
    logic [fat_pkg::STAT_W-1:0] st_reg, st_next;
    logic [SIZE_W-1:0]          fda_reg;

    logic                         rsp_vld_reg, rsp_vld_next;
    logic [fat_pkg::STAT_W-1:0]   rsp_st_reg, rsp_st_next;
    logic [fat_pkg::INDEX_W-1:0]  rsp_idx_reg, rsp_idx_next;
    logic [ADDR_W-1:0]            rsp_addr_reg, rsp_addr_next;
    logic [SIZE_W-1:0]            rsp_size_reg, rsp_size_next;
    logic [fat_pkg::COUNT_W-1:0]  rsp_cnt_reg, rsp_cnt_next;
    logic [ADDR_W-1:0]            rsp_free_reg, rsp_free_next;

    logic              accept;
    logic              out_free;
    logic [ADDR_W-1:0] end_eff;
    logic [ADDR_W-1:0] room;
    logic              store_fail;
    logic              hit;
    logic              last_cmp;
    logic              ptr_live;
    logic              shift_done;

    assign req.ready = (state_reg == fat_pkg::S_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_vld_reg || rsp.ready;

    // An empty table ends where the first file would start.
    assign end_eff    = (cnt_reg == '0) ? ADDR_W'(fda_reg) : end_reg;
    assign room       = fat_pkg::room_left(end_eff);
    assign store_fail = (cnt_reg >= CNT_W'(fat_pkg::MAX_ENTRIES))
                        || !(room > ADDR_W'(req.file_size));
    assign hit        = rvld_reg && (ram_rdata.name == key_reg);
    assign last_cmp   = rvld_reg && (rptr_reg == IDX_W'(cnt_reg - CNT_W'(1)));
    assign ptr_live   = (ptr_reg < cnt_reg);
    assign shift_done = !ptr_live && !rvld_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fat_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (req.command)
                        fat_pkg::CMD_STORE:
                        begin
                            if (store_fail)
                                state_next = fat_pkg::S_FINISH;
                            else if (cnt_reg == '0)
                                state_next = fat_pkg::S_WRITE;
                            else
                                state_next = fat_pkg::S_SCAN;
                        end
                        fat_pkg::CMD_FIND, fat_pkg::CMD_ERASE:
                        begin
                            state_next = (cnt_reg == '0) ? fat_pkg::S_FINISH : fat_pkg::S_SCAN;
                        end
                        default:
                        begin
                            state_next = fat_pkg::S_FINISH;
                        end
                    endcase
                end
            end
            fat_pkg::S_SCAN:
            begin
                if (hit)
                    state_next = (cmd_reg == fat_pkg::CMD_ERASE) ? fat_pkg::S_SHIFT
                                                                 : fat_pkg::S_FINISH;
                else if (last_cmp)
                    state_next = (cmd_reg == fat_pkg::CMD_STORE) ? fat_pkg::S_WRITE
                                                                 : fat_pkg::S_FINISH;
            end
            fat_pkg::S_WRITE:
            begin
                state_next = fat_pkg::S_FINISH;
            end
            fat_pkg::S_SHIFT:
            begin
                if (shift_done)
                    state_next = (cnt_reg > CNT_W'(1)) ? fat_pkg::S_TAIL : fat_pkg::S_FINISH;
            end
            fat_pkg::S_TAIL:
            begin
                state_next = fat_pkg::S_FINISH;
            end
            fat_pkg::S_FINISH:
            begin
                if (out_free)
                    state_next = fat_pkg::S_IDLE;
            end
            default:
            begin
                state_next = fat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        size_next     = size_reg;
        cnt_next      = cnt_reg;
        end_next      = end_reg;
        ptr_next      = ptr_reg;
        rvld_next     = 1'b0;
        rptr_next     = rptr_reg;
        hit_idx_next  = hit_idx_reg;
        hit_addr_next = hit_addr_reg;
        hit_size_next = hit_size_reg;
        st_next       = st_reg;
        ram_req.we    = 1'b0;
        ram_req.waddr = rptr_reg - IDX_W'(1);
        ram_req.wdata = ram_rdata;
        ram_req.raddr = ptr_live ? ptr_reg[IDX_W-1:0] : '0;

        rsp_vld_next  = rsp_vld_reg && !rsp.ready;
        rsp_st_next   = rsp_st_reg;
        rsp_idx_next  = rsp_idx_reg;
        rsp_addr_next = rsp_addr_reg;
        rsp_size_next = rsp_size_reg;
        rsp_cnt_next  = rsp_cnt_reg;
        rsp_free_next = rsp_free_reg;

        case (state_reg)
            fat_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = req.command;
                    key_next      = req.name_key;
                    size_next     = req.file_size;
                    ptr_next      = '0;
                    hit_idx_next  = '0;
                    hit_addr_next = '0;
                    hit_size_next = '0;
                    st_next       = fat_pkg::ST_OK;
                    if (req.command == fat_pkg::CMD_STORE && store_fail)
                        st_next = fat_pkg::ST_NOSPACE;
                    else if ((req.command == fat_pkg::CMD_FIND
                              || req.command == fat_pkg::CMD_ERASE) && cnt_reg == '0)
                        st_next = fat_pkg::ST_MISSING;
                end
            end
            fat_pkg::S_SCAN:
            begin
                if (ptr_live)
                begin
                    ptr_next  = ptr_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                    rptr_next = ptr_reg[IDX_W-1:0];
                end
                if (hit)
                begin
                    if (cmd_reg == fat_pkg::CMD_STORE)
                    begin
                        st_next = fat_pkg::ST_EXISTS;
                    end
                    else
                    begin
                        hit_idx_next  = rptr_reg;
                        hit_addr_next = ram_rdata.addr;
                        hit_size_next = ram_rdata.size;
                    end
                    if (cmd_reg == fat_pkg::CMD_ERASE)
                    begin
                        // Drop the read issued this cycle and restart after the hit.
                        ptr_next  = CNT_W'(rptr_reg) + CNT_W'(1);
                        rvld_next = 1'b0;
                    end
                end
                else if (last_cmp && cmd_reg != fat_pkg::CMD_STORE)
                begin
                    st_next = fat_pkg::ST_MISSING;
                end
            end
            fat_pkg::S_WRITE:
            begin
                ram_req.we         = 1'b1;
                ram_req.waddr      = cnt_reg[IDX_W-1:0];
                ram_req.wdata.name = key_reg;
                ram_req.wdata.addr = end_eff;
                ram_req.wdata.size = size_reg;
                hit_idx_next       = cnt_reg[IDX_W-1:0];
                hit_addr_next      = end_eff;
                hit_size_next      = size_reg;
                end_next           = ADDR_W'(end_eff + ADDR_W'(size_reg));
                cnt_next           = cnt_reg + CNT_W'(1);
            end
            fat_pkg::S_SHIFT:
            begin
                // Entry read at one cycle lands one place lower in the next.
                if (ptr_live)
                begin
                    ptr_next  = ptr_reg + CNT_W'(1);
                    rvld_next = 1'b1;
                    rptr_next = ptr_reg[IDX_W-1:0];
                end
                if (rvld_reg)
                    ram_req.we = 1'b1;
                if (shift_done)
                begin
                    cnt_next      = cnt_reg - CNT_W'(1);
                    ram_req.raddr = IDX_W'(cnt_reg - CNT_W'(2));
                end
            end
            fat_pkg::S_TAIL:
            begin
                end_next = ADDR_W'(ram_rdata.addr + ADDR_W'(ram_rdata.size));
            end
            fat_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    rsp_vld_next  = 1'b1;
                    rsp_st_next   = st_reg;
                    rsp_idx_next  = fat_pkg::INDEX_W'(hit_idx_reg);
                    rsp_addr_next = hit_addr_reg;
                    rsp_size_next = hit_size_reg;
                    rsp_cnt_next  = fat_pkg::COUNT_W'(cnt_reg);
                    rsp_free_next = room;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fat_pkg::S_IDLE;
            cnt_reg     <= '0;
            rvld_reg    <= 1'b0;
            rsp_vld_reg <= 1'b0;
            fda_reg     <= fat_pkg::FIRST_DATA_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rvld_reg    <= rvld_next;
            rsp_vld_reg <= rsp_vld_next;
            if (cfg.valid)
                fda_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        size_reg     <= size_next;
        end_reg      <= end_next;
        ptr_reg      <= ptr_next;
        rptr_reg     <= rptr_next;
        hit_idx_reg  <= hit_idx_next;
        hit_addr_reg <= hit_addr_next;
        hit_size_reg <= hit_size_next;
        st_reg       <= st_next;
        rsp_st_reg   <= rsp_st_next;
        rsp_idx_reg  <= rsp_idx_next;
        rsp_addr_reg <= rsp_addr_next;
        rsp_size_reg <= rsp_size_next;
        rsp_cnt_reg  <= rsp_cnt_next;
        rsp_free_reg <= rsp_free_next;
    end

    assign rsp.valid         = rsp_vld_reg;
    assign rsp.status        = rsp_st_reg;
    assign rsp.entry_index   = rsp_idx_reg;
    assign rsp.start_address = rsp_addr_reg;
    assign rsp.entry_size    = rsp_size_reg;
    assign rsp.file_count    = rsp_cnt_reg;
    assign rsp.free_bytes    = rsp_free_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(fat_pkg::MAX_ENTRIES))
        else $error("file count exceeds table depth");

    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.we |-> (state_reg == fat_pkg::S_WRITE || state_reg == fat_pkg::S_SHIFT))
        else $error("table written outside store or shift");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != fat_pkg::S_IDLE)
        else $error("accepted item did not start work");

    a_cnt_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(cnt_reg) |-> ($past(state_reg) == fat_pkg::S_WRITE
                               || $past(state_reg) == fat_pkg::S_SHIFT))
        else $error("file count changed outside store or erase");

endmodule

### hdl/file_allocation_table.sv
// File allocation table: a small directory of files kept in address order.
// Channel req takes one command item (store, find or erase) with a packed
// name and a size; channel rsp returns exactly one result item per command
// with status, entry index, start address, size, file count and free bytes.
// Channel cfg writes the first data address; write it only while idle.
// Entries live in a memory with one read and one write port and a registered
// read, so the work is one entry per cycle. A find, or a store whose name
// exists, compares entries in order until the name is hit or the table ends;
// a store that appends compares every entry and then writes the new one (on
// an empty table it writes at once); an erase works as a find, then shifts
// each later entry down one place to close the gap and re-reads the new last
// entry for the end address, unless the table is now empty. A command that
// fails the space check, a find or erase on an empty table, or an unused
// command goes straight to its result. One command is worked on at a time;
// a new one is accepted as soon as the previous result is in the output
// register, even if not yet taken.
// If rsp is stalled, the block holds its finished result until the output
// register frees up. Reset empties the table and sets the first data address
// to 161; entry contents are not cleared.
module file_allocation_table
(
    input  logic      clk,
    input  logic      rst_n,
    fat_req_if.sink   req,
    fat_rsp_if.source rsp,
    fat_cfg_if.sink   cfg
);

    fat_pkg::ram_req_t ram_req;
    fat_pkg::entry_t   ram_rdata;

    fat_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg       (cfg),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata)
    );

    fat_ram u_ram
    (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

endmodule

### tb/tb_file_allocation_table.sv
`timescale 1ns / 100ps

module tb_file_allocation_table;
    import fat_pkg::*;

    // The block decodes command 3 as a no-op that still answers.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int SEGMENTS      = 6;
    localparam int SEG_ITEMS     = 80;
    localparam int SETTLE_CYCLES = 2 * MAX_ENTRIES + 12;
    localparam int DIRECTED_ROWS = 24;

    localparam logic [KEY_W-1:0] NAME_ZERO = '0;
    localparam logic [KEY_W-1:0] NAME_ONES = '1;
    localparam logic [KEY_W-1:0] NAME_LOG  = "log";
    localparam logic [KEY_W-1:0] NAME_CFG  = "config.x";

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [INDEX_W-1:0] idx;
        logic [ADDR_W-1:0]  addr;
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
        logic [ADDR_W-1:0]  bytes_free;
    } fat_result_t;

    typedef struct packed {
        logic              set_base;
        logic [SIZE_W-1:0] base_value;
        logic [CMD_W-1:0]  command;
        logic [KEY_W-1:0]  name_key;
        logic [SIZE_W-1:0] file_size;
        logic              typed;
        fat_result_t       result;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    fat_req_if req_ch();
    fat_rsp_if rsp_ch();
    fat_cfg_if cfg_ch();

    file_allocation_table u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Directory as the block should hold it.
    logic [KEY_W-1:0]  dir_name [MAX_ENTRIES];
    logic [ADDR_W-1:0] dir_addr [MAX_ENTRIES];
    logic [SIZE_W-1:0] dir_size [MAX_ENTRIES];
    int                dir_count = 0;
    logic [SIZE_W-1:0] base_addr = FIRST_DATA_RESET;

    fat_result_t pending_results [$];
    fat_result_t rsp_seen;
    fat_result_t rsp_want;

    logic [KEY_W-1:0] recent_names [8] = '{default: '0};
    int recent_wr = 0;

    int send_idle_pct   = 23;
    int recv_idle_pct   = 52;
    int sink_stall_left = 0;

    int failures       = 0;
    int commands_sent  = 0;
    int results_seen   = 0;
    int files_placed   = 0;
    int files_erased   = 0;
    int refusals       = 0;
    int base_writes    = 0;

    // Status, index, address, size, file count, free bytes.
    directed_row_t directed_cmds [DIRECTED_ROWS] = '{
        // Find and erase on the empty table.
        '{1'b0, 10'd0, CMD_FIND, NAME_LOG, 10'd0,
          1'b1, '{ST_MISSING, 4'd0, 11'd0, 10'd0, 4'd0, 11'd863}},
        '{1'b0, 10'd0, CMD_ERASE, NAME_LOG, 10'd0,
          1'b1, '{ST_MISSING, 4'd0, 11'd0, 10'd0, 4'd0, 11'd863}},
        '{1'b0, 10'd0, CMD_STORE, NAME_ZERO, 10'd0,
          1'b1, '{ST_OK, 4'd0, 11'd161, 10'd0, 4'd1, 11'd863}},
        '{1'b0, 10'd0, CMD_STORE, NAME_ONES, 10'd1023,
          1'b1, '{ST_NOSPACE, 4'd0, 11'd0, 10'd0, 4'd1, 11'd863}},
        '{1'b0, 10'd0, CMD_STORE, NAME_ZERO, 10'd5,
          1'b1, '{ST_EXISTS, 4'd0, 11'd0, 10'd0, 4'd1, 11'd863}},
        // Fill up to one byte below the top of the store.
        '{1'b0, 10'd0, CMD_STORE, NAME_ONES, 10'd862,
          1'b1, '{ST_OK, 4'd1, 11'd161, 10'd862, 4'd2, 11'd1}},
        '{1'b0, 10'd0, CMD_STORE, NAME_LOG, 10'd0,
          1'b1, '{ST_OK, 4'd2, 11'd1023, 10'd0, 4'd3, 11'd1}},
        '{1'b0, 10'd0, CMD_STORE, NAME_CFG, 10'd1,
          1'b1, '{ST_NOSPACE, 4'd0, 11'd0, 10'd0, 4'd3, 11'd1}},
        // Room is checked before the name.
        '{1'b0, 10'd0, CMD_STORE, NAME_ZERO, 10'd1,
          1'b1, '{ST_NOSPACE, 4'd0, 11'd0, 10'd0, 4'd3, 11'd1}},
        '{1'b0, 10'd0, CMD_FIND, NAME_ONES, 10'd0, 1'b0, '0},
        '{1'b0, 10'd0, CMD_ERASE, NAME_ZERO, 10'd0, 1'b0, '0},
        '{1'b0, 10'd0, CMD_UNUSED, NAME_ONES, 10'd1023,
          1'b1, '{ST_OK, 4'd0, 11'd0, 10'd0, 4'd2, 11'd1}},
        '{1'b0, 10'd0, CMD_ERASE, NAME_ONES, 10'd0, 1'b0, '0},
        '{1'b0, 10'd0, CMD_ERASE, NAME_LOG, 10'd0, 1'b0, '0},
        // Highest base address: one byte of room on an empty table.
        '{1'b1, 10'd1023, CMD_STORE, NAME_CFG, 10'd1,
          1'b1, '{ST_NOSPACE, 4'd0, 11'd0, 10'd0, 4'd0, 11'd1}},
        '{1'b0, 10'd0, CMD_STORE, NAME_CFG, 10'd0,
          1'b1, '{ST_OK, 4'd0, 11'd1023, 10'd0, 4'd1, 11'd1}},
        '{1'b0, 10'd0, CMD_FIND, NAME_CFG, 10'd0, 1'b0, '0},
        '{1'b0, 10'd0, CMD_ERASE, NAME_CFG, 10'd0, 1'b0, '0},
        '{1'b1, 10'd0, CMD_STORE, NAME_LOG, 10'd1023,
          1'b1, '{ST_OK, 4'd0, 11'd0, 10'd1023, 4'd1, 11'd1}},
        '{1'b0, 10'd0, CMD_STORE, NAME_ONES, 10'd0,
          1'b1, '{ST_OK, 4'd1, 11'd1023, 10'd0, 4'd2, 11'd1}},
        '{1'b0, 10'd0, CMD_FIND, NAME_LOG, 10'd0, 1'b0, '0},
        '{1'b0, 10'd0, CMD_ERASE, NAME_LOG, 10'd0, 1'b0, '0},
        '{1'b0, 10'd0, CMD_FIND, NAME_ONES, 10'd0, 1'b0, '0},
        '{1'b0, 10'd0, CMD_ERASE, NAME_ONES, 10'd0, 1'b0, '0}
    };

    function automatic logic [ADDR_W-1:0] dir_end();
        if (dir_count == 0)
            return ADDR_W'(base_addr);
        return dir_addr[dir_count - 1] + ADDR_W'(dir_size[dir_count - 1]);
    endfunction

    function automatic logic [ADDR_W-1:0] dir_room();
        logic [ADDR_W-1:0] last;
        last = dir_end();
        return (last >= ADDR_W'(STORE_BYTES)) ? '0 : ADDR_W'(STORE_BYTES) - last;
    endfunction

    function automatic int dir_lookup(input logic [KEY_W-1:0] key);
        for (int i = 0; i < dir_count; i++)
        begin
            if (dir_name[i] == key)
                return i;
        end
        return -1;
    endfunction

    // Updates the directory for one command and returns the answer it should give.
    function automatic fat_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [SIZE_W-1:0] fsize);
        fat_result_t r;
        int slot;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_STORE:
            begin
                if (dir_count >= MAX_ENTRIES || dir_room() <= ADDR_W'(fsize))
                    r.status = ST_NOSPACE;
                else if (dir_lookup(key) >= 0)
                    r.status = ST_EXISTS;
                else
                begin
                    r.idx  = INDEX_W'(dir_count);
                    r.addr = dir_end();
                    r.size = fsize;
                    dir_name[dir_count] = key;
                    dir_addr[dir_count] = r.addr;
                    dir_size[dir_count] = fsize;
                    dir_count++;
                end
            end
            CMD_FIND, CMD_ERASE:
            begin
                slot = dir_lookup(key);
                if (slot < 0)
                    r.status = ST_MISSING;
                else
                begin
                    r.idx  = INDEX_W'(slot);
                    r.addr = dir_addr[slot];
                    r.size = dir_size[slot];
                    if (cmd == CMD_ERASE)
                    begin
                        for (int i = slot; i + 1 < dir_count; i++)
                        begin
                            dir_name[i] = dir_name[i + 1];
                            dir_addr[i] = dir_addr[i + 1];
                            dir_size[i] = dir_size[i + 1];
                        end
                        dir_count--;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count      = COUNT_W'(dir_count);
        r.bytes_free = dir_room();
        return r;
    endfunction

    // Offers one command item and books its answer once the block takes it.
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                         input logic [SIZE_W-1:0] fsize, input logic typed,
                         input fat_result_t typed_result);
        int gap;
        fat_result_t predicted;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.command   <= cmd;
        req_ch.name_key  <= key;
        req_ch.file_size <= fsize;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = apply_command(cmd, key, fsize);
        pending_results.push_back(typed ? typed_result : predicted);
        commands_sent++;
        recent_names[recent_wr] = key;
        recent_wr = (recent_wr + 1) % 8;
        if (predicted.status == ST_NOSPACE)
            refusals++;
        else if (predicted.status == ST_OK && cmd == CMD_STORE)
            files_placed++;
        else if (predicted.status == ST_OK && cmd == CMD_ERASE)
            files_erased++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_base(input logic [SIZE_W-1:0] value);
        drain();
        // A store that fails early can finish before a long erase would have.
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        base_addr = value;
        base_writes++;
    endtask

    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_stall_left > 0)
            begin
                sink_stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_seen = {rsp_ch.status, rsp_ch.entry_index, rsp_ch.start_address,
                        rsp_ch.entry_size, rsp_ch.file_count, rsp_ch.free_bytes};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("result %0d arrived with no command waiting for it",
                             results_seen);
            end
            else
            begin
                rsp_want = pending_results.pop_front();
                if (rsp_seen !== rsp_want)
                begin
                    failures++;
                    if (failures <= 10)
                        $display({"result %0d: expected st=%0d idx=%0d addr=%0d size=%0d ",
                                  "files=%0d free=%0d, got st=%0d idx=%0d addr=%0d ",
                                  "size=%0d files=%0d free=%0d"},
                                 results_seen, rsp_want.status, rsp_want.idx,
                                 rsp_want.addr, rsp_want.size, rsp_want.count,
                                 rsp_want.bytes_free, rsp_seen.status, rsp_seen.idx,
                                 rsp_seen.addr, rsp_seen.size, rsp_seen.count,
                                 rsp_seen.bytes_free);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_file_allocation_table failed");
        $finish;
    end

    initial
    begin
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key;
        logic [SIZE_W-1:0] fsize;
        logic [SIZE_W-1:0] next_base;
        int pick;

        req_ch.valid     <= 1'b0;
        req_ch.command   <= CMD_STORE;
        req_ch.name_key  <= '0;
        req_ch.file_size <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.data      <= '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_cmds[i])
        begin
            if (directed_cmds[i].set_base)
                write_base(directed_cmds[i].base_value);
            offer(directed_cmds[i].command, directed_cmds[i].name_key,
                  directed_cmds[i].file_size, directed_cmds[i].typed,
                  directed_cmds[i].result);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: next_base = FIRST_DATA_RESET;
                1: next_base = 10'd1023;
                2: next_base = SIZE_W'($urandom_range(1023));
                3: next_base = 10'd0;
                4: next_base = SIZE_W'($urandom_range(1023, 700));
                default: next_base = SIZE_W'($urandom_range(400));
            endcase
            write_base(next_base);
            if (seg == 2)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 23;
            end
            else if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                // Long output stall while commands keep coming, so the input backs up.
                if (seg == 4 && n == 10)
                    sink_stall_left = 300;
                if (seg == 2 && n == 40)
                    drain();

                pick = $urandom_range(99);
                if (pick < 45)
                    cmd = CMD_STORE;
                else if (pick < 65)
                    cmd = CMD_FIND;
                else if (pick < 95)
                    cmd = CMD_ERASE;
                else
                    cmd = CMD_UNUSED;

                // Stores mostly bring new names; find and erase mostly hit the table.
                pick = $urandom_range(99);
                if (cmd == CMD_STORE)
                    pick = pick + 50;
                if (pick < 65 && dir_count > 0)
                    key = dir_name[$urandom_range(dir_count - 1)];
                else if (pick < 80)
                    key = recent_names[$urandom_range(7)];
                else
                    key = {$urandom, $urandom} >> (8 * $urandom_range(7));

                pick = $urandom_range(99);
                if (pick < 65)
                    fsize = SIZE_W'($urandom_range(40));
                else if (pick < 85)
                    fsize = SIZE_W'($urandom_range(1023));
                else if (pick < 93)
                    fsize = '0;
                else
                    fsize = '1;

                offer(cmd, key, fsize, 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d commands (%0d scripted) and compared %0d answers, %0d failures.",
                 commands_sent, DIRECTED_ROWS, results_seen, failures);
        $display("Files placed %0d, erased %0d, refused for room %0d, base writes %0d.",
                 files_placed, files_erased, refusals, base_writes);
        if (failures == 0)
            $display("tb_file_allocation_table passed");
        else
            $display("tb_file_allocation_table failed");
        $finish;
    end

endmodule

### filelist.f
hdl/fat_pkg.sv
hdl/fat_if.sv
hdl/fat_ram.sv
hdl/fat_ctrl.sv
hdl/file_allocation_table.sv
tb/tb_file_allocation_table.sv
